// File: rtl/wjce_pkg.sv
package wjce_pkg;

  localparam int unsigned HerdSize   = 256;
  localparam int unsigned MaxHistory = 8;
  localparam int unsigned WalkerW    = $clog2(HerdSize);
  localparam int unsigned SlotW      = $clog2(MaxHistory);
  localparam int unsigned CountW     = $clog2(MaxHistory + 1);
  localparam int unsigned AddrW      = WalkerW + SlotW;
  localparam int unsigned HistDepth  = HerdSize * MaxHistory;

  localparam logic [63:0] Golden   = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MultA    = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MultB    = 64'h94D049BB133111EB;
  localparam logic [63:0] SaltJump = 64'hD1B54A32D192ED03;
  localparam logic [63:0] SaltEsc  = 64'h2545F4914F6CDD1D;

  localparam logic [1:0] RegFold  = 2'd0;
  localparam logic [1:0] RegJump  = 2'd1;
  localparam logic [1:0] RegDepth = 2'd2;
  localparam logic [1:0] RegDp    = 2'd3;

  // Requests to the shared mixer.
  typedef struct packed {
    logic        start;
    logic [63:0] z;
  } mix_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] y;
  } mix_rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_MIX_A,
    S_MIX_B,
    S_MIX_W0,
    S_MIX_W1,
    S_MIX_W2,
    S_MIX_W3,
    S_DECIDE,
    S_RD,
    S_RD_WAIT,
    S_CMP,
    S_ESC,
    S_BUMP,
    S_SHIFT_RD,
    S_SHIFT_WAIT,
    S_SHIFT_WR,
    S_APPEND,
    S_OUT
  } state_e;

endpackage

// File: rtl/wjce_ram.sv
module wjce_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/wjce_mix.sv
// Splitmix finaliser over several cycles: each 64x64 product is split into
// three 32x32 partial products, one per cycle.
module wjce_mix
  import wjce_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mix_req_t req_i,
  output mix_rsp_t rsp_o
);

  logic [63:0] val_q, val_d;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  part_q, part_d;
  logic        round_q, round_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] mult;
  logic [31:0] pa, pb;
  logic [63:0] prod;
  logic [63:0] term;

  assign mult = round_q ? MultB : MultA;

  always_comb begin
    pa = val_q[31:0];
    pb = mult[31:0];
    case (part_q)
      2'd0: begin pa = val_q[31:0];  pb = mult[31:0];  end
      2'd1: begin pa = val_q[63:32]; pb = mult[31:0];  end
      2'd2: begin pa = val_q[31:0];  pb = mult[63:32]; end
      default: begin pa = val_q[31:0]; pb = mult[31:0]; end
    endcase
    prod = {32'd0, pa} * {32'd0, pb};
    term = (part_q == 2'd0) ? prod : {prod[31:0], 32'd0};
  end

  always_comb begin
    val_d   = val_q;
    acc_d   = acc_q;
    part_d  = part_q;
    round_d = round_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      val_d   = (req_i.z + Golden) ^ ((req_i.z + Golden) >> 30);
      acc_d   = '0;
      part_d  = 2'd0;
      round_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      // Advance one partial product.
      if (part_q == 2'd2) begin
        if (!round_q) begin
          val_d   = (acc_q + term) ^ ((acc_q + term) >> 27);
          acc_d   = '0;
          part_d  = 2'd0;
          round_d = 1'b1;
        end else begin
          acc_d  = (acc_q + term) ^ ((acc_q + term) >> 31);
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        acc_d  = acc_q + term;
        part_d = part_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      part_q  <= 2'd0;
      round_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      part_q  <= part_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    acc_q <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.y    = acc_q;

endmodule

// File: rtl/walker_jump_and_cycle_escape.sv
// Jump selection for a folded kangaroo walk, one walker position per beat.
//
// Input channel: in_valid_i / in_stall_o with walker_i, x_word0_i..x_word3_i
// and reseeded_i. Output channel: out_valid_o / out_stall_i with next_jump_o,
// cycle_found_o and distinguished_o; one result beat per input beat, in order.
// Configuration: cfg_we_i, cfg_index_i, cfg_data_i; write only while idle.
//
// Processing: six splitmix evaluations on one shared mixer, then a history
// pass over up to depth entries, an optional escape mix and a shift of the
// window of up to depth-1 entries. One item is in flight at a time;
// in_stall_o is high from acceptance until the result beat is taken.
//
// After reset the registers take their reset values and a pass over all
// 256 walkers clears their fill counts, with in_stall_o high. The hash RAM needs
// no clearing, as a slot is read only below the walker's fill count. While
// out_stall_i is high the result beat holds.
module walker_jump_and_cycle_escape
  import wjce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  walker_i,
  input  logic [63:0] x_word0_i,
  input  logic [63:0] x_word1_i,
  input  logic [63:0] x_word2_i,
  input  logic [63:0] x_word3_i,
  input  logic        reseeded_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] next_jump_o,
  output logic        cycle_found_o,
  output logic        distinguished_o
);

  // Configuration registers.
  logic       fold_q;
  logic [4:0] jbits_q;
  logic [3:0] depth_q;
  logic [5:0] dpbits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q   <= 1'b1;
      jbits_q  <= 5'd5;
      depth_q  <= 4'd8;
      dpbits_q <= 6'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegFold:  fold_q   <= cfg_data_i[0];
        RegJump:  jbits_q  <= cfg_data_i[4:0];
        RegDepth: depth_q  <= cfg_data_i[3:0];
        RegDp:    dpbits_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Saturated configuration.
  logic [4:0]  jb;
  logic [15:0] jmask;
  logic [CountW-1:0] depth;
  logic [5:0]  db;
  logic [31:0] dmask;

  always_comb begin
    jb = (jbits_q == 5'd0) ? 5'd1 : ((jbits_q > 5'd16) ? 5'd16 : jbits_q);
    jmask = 16'((17'd1 << jb) - 17'd1);
    if (depth_q < 4'd2) depth = CountW'(2);
    else if ({1'b0, depth_q} > 5'(MaxHistory)) depth = CountW'(MaxHistory);
    else depth = CountW'(depth_q);
    db = (dpbits_q > 6'd32) ? 6'd32 : dpbits_q;
    dmask = 32'((33'd1 << db) - 33'd1);
  end

  // Item registers.
  state_e      state_q, state_d;
  logic [WalkerW-1:0] walker_q;
  logic [63:0] w0_q, w1_q, w2_q, w3_q;
  logic        reseed_q;
  logic [63:0] nat_q, hash_q, anchor_q, esc_q;
  logic [15:0] jump_q;
  logic        cycle_q, dp_q;
  logic [CountW-1:0] cnt_q, idx_q;

  // Per-walker fill counts in RAM, cleared by a pass after reset.
  logic [WalkerW-1:0] clr_q;
  logic               cnt_we;
  logic [WalkerW-1:0] cnt_waddr;
  logic [CountW-1:0]  cnt_wdata, cnt_raw, cnt_sat;
  wjce_ram #(.Width(CountW), .Depth(HerdSize)) u_count (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(walker_q), .rdata_o(cnt_raw)
  );
  assign cnt_sat = (cnt_raw > depth) ? depth : cnt_raw;

  // Shared mixer.
  mix_req_t mreq;
  mix_rsp_t mrsp;
  wjce_mix u_mix (.clk_i, .rst_ni, .req_i(mreq), .rsp_o(mrsp));

  // History RAM.
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [63:0]       ram_wdata, ram_rdata;
  wjce_ram #(.Width(64), .Depth(HistDepth)) u_hist (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  logic accept;
  assign accept = (state_q == S_IDLE) && in_valid_i;

  // Repeat seen so far, including the entry under compare.
  logic hit;
  assign hit = cycle_q || (ram_rdata == hash_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_q == WalkerW'(HerdSize - 1)) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_MIX_A;
      S_MIX_A:  if (mrsp.done) state_d = S_MIX_B;
      S_MIX_B:  if (mrsp.done) state_d = S_MIX_W0;
      S_MIX_W0: if (mrsp.done) state_d = S_MIX_W1;
      S_MIX_W1: if (mrsp.done) state_d = S_MIX_W2;
      S_MIX_W2: if (mrsp.done) state_d = S_MIX_W3;
      S_MIX_W3: if (mrsp.done) state_d = S_DECIDE;
      S_DECIDE: begin
        if (reseed_q || !fold_q) state_d = S_OUT;
        else if (cnt_sat == '0) state_d = S_APPEND;
        else state_d = S_RD;
      end
      S_RD:      state_d = S_RD_WAIT;
      S_RD_WAIT: state_d = S_CMP;
      S_CMP: begin
        if (idx_q + CountW'(1) < cnt_q) state_d = S_RD;
        else if (hit) state_d = S_ESC;
        else if (cnt_q < depth) state_d = S_APPEND;
        else if (depth > CountW'(1)) state_d = S_SHIFT_RD;
        else state_d = S_APPEND;
      end
      S_ESC:  if (mrsp.done) state_d = S_BUMP;
      S_BUMP: state_d = S_OUT;
      S_SHIFT_RD:   state_d = S_SHIFT_WAIT;
      S_SHIFT_WAIT: state_d = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (idx_q + CountW'(1) < depth - CountW'(1)) state_d = S_SHIFT_RD;
        else state_d = S_APPEND;
      end
      S_APPEND: state_d = S_OUT;
      S_OUT:    if (!out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: mixer requests and RAM ports.
  logic mix_go;
  always_comb begin
    mix_go = 1'b0;
    case (state_q)
      S_IDLE:   mix_go = in_valid_i;
      S_MIX_A, S_MIX_B, S_MIX_W0, S_MIX_W1, S_MIX_W2: mix_go = mrsp.done;
      S_CMP:    mix_go = (idx_q + CountW'(1) >= cnt_q) && hit;
      default:  mix_go = 1'b0;
    endcase
  end

  // The mixer input for the next state is launched on the transition.
  always_comb begin
    mreq.start = mix_go;
    case (state_q)
      S_IDLE:   mreq.z = {x_word1_i[31:0], x_word0_i[63:32]};
      S_MIX_A:  mreq.z = {w3_q[31:0], w2_q[63:32]} ^ SaltJump;
      S_MIX_B:  mreq.z = w0_q;
      S_MIX_W0: mreq.z = w1_q;
      S_MIX_W1: mreq.z = w2_q;
      S_MIX_W2: mreq.z = w3_q;
      S_CMP:    mreq.z = ((ram_rdata < anchor_q) ? ram_rdata : anchor_q) ^ SaltEsc;
      default:  mreq.z = 64'd0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {walker_q, SlotW'(0)};
    ram_wdata = ram_rdata;
    ram_raddr = {walker_q, idx_q[SlotW-1:0]};
    case (state_q)
      S_SHIFT_RD, S_SHIFT_WAIT: ram_raddr = {walker_q, SlotW'(idx_q + CountW'(1))};
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {walker_q, idx_q[SlotW-1:0]};
      end
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_wdata = hash_q;
        ram_waddr = (cnt_q < depth) ? {walker_q, cnt_q[SlotW-1:0]}
                                    : {walker_q, SlotW'(depth - CountW'(1))};
      end
      default: ;
    endcase
  end

  // Fill count writes: clear pass, reseed, escape and record.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = walker_q;
    cnt_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
      end
      S_DECIDE: cnt_we = reseed_q;
      S_BUMP:   cnt_we = 1'b1;
      S_APPEND: begin
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_q < depth) ? cnt_q + CountW'(1) : depth;
      end
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      walker_q <= WalkerW'(walker_i);
      w0_q     <= x_word0_i;
      w1_q     <= x_word1_i;
      w2_q     <= x_word2_i;
      w3_q     <= x_word3_i;
      reseed_q <= reseeded_i;
      dp_q     <= (x_word0_i[31:0] & dmask) == 32'd0;
    end
    case (state_q)
      S_MIX_A:  if (mrsp.done) nat_q <= mrsp.y;
      S_MIX_B:  if (mrsp.done) nat_q <= nat_q ^ mrsp.y;
      S_MIX_W0: if (mrsp.done) hash_q <= mrsp.y;
      S_MIX_W1, S_MIX_W2: if (mrsp.done) hash_q <= hash_q ^ mrsp.y;
      S_MIX_W3: if (mrsp.done) hash_q <= hash_q ^ mrsp.y;
      S_DECIDE: begin
        jump_q   <= nat_q[15:0] & jmask;
        cycle_q  <= 1'b0;
        anchor_q <= hash_q;
        idx_q    <= '0;
        cnt_q    <= cnt_sat;
      end
      S_CMP: begin
        if (ram_rdata == hash_q) cycle_q <= 1'b1;
        if (ram_rdata < anchor_q) anchor_q <= ram_rdata;
        if (state_d == S_RD) idx_q <= idx_q + CountW'(1);
        else idx_q <= '0;
      end
      S_ESC: if (mrsp.done) esc_q <= mrsp.y;
      S_BUMP: begin
        if ((esc_q[15:0] & jmask) == jump_q) jump_q <= (jump_q + 16'd1) & jmask;
        else jump_q <= esc_q[15:0] & jmask;
      end
      S_SHIFT_WR: idx_q <= idx_q + CountW'(1);
      default: ;
    endcase
  end

  // Control and clear pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + WalkerW'(1);
    end
  end

  // A cycle result must be re-evaluated at DECIDE so clear it there for off paths.
  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign next_jump_o     = (state_q == S_OUT && (reseed_q || !fold_q || !cycle_q))
                           ? ((reseed_q || !fold_q) ? nat_q[15:0] & jmask : jump_q)
                           : jump_q;
  assign cycle_found_o   = cycle_q && !reseed_q && fold_q;
  assign distinguished_o = dp_q;

`ifndef SYNTHESIS
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o) else $error("result repeated");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accepting while result pending");
  a_mix_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mrsp.done |-> !mreq.start || state_q != S_IDLE) else $error("mixer misuse");
`endif

endmodule

// File: tb/sv/testbench.sv
module testbench
  import wjce_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One result beat as the block should return it.
  typedef struct packed {
    logic [15:0] jump;
    logic        cycle;
    logic        dp;
  } jump_result_t;

  // One walker position.
  typedef struct packed {
    logic [7:0]  walker;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
    logic        reseed;
  } position_t;

  // Directed row: a position plus, where obvious, the flags it must give.
  typedef struct packed {
    position_t pos;
    logic      typed;
    logic      cycle;
    logic      dp;
  } directed_row_t;

  // Register setting for one phase of the run.
  typedef struct packed {
    logic [5:0] fold;
    logic [5:0] jbits;
    logic [5:0] depth;
    logic [5:0] dpb;
  } setting_t;

  localparam int unsigned NumRows    = 12;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned PhaseItems = 210;
  localparam int unsigned PoolSize   = 6;
  localparam logic [63:0] Ones       = '1;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = RegFold;
  logic [5:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  walker_i    = '0;
  logic [63:0] x_word0_i   = '0;
  logic [63:0] x_word1_i   = '0;
  logic [63:0] x_word2_i   = '0;
  logic [63:0] x_word3_i   = '0;
  logic        reseeded_i  = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] next_jump_o;
  logic        cycle_found_o;
  logic        distinguished_o;

  walker_jump_and_cycle_escape DUT (.*);

  // Predictor state: the per-walker hash windows and fill counts.
  logic [63:0] orbit_window [HerdSize][MaxHistory];
  int unsigned orbit_fill   [HerdSize];
  logic        fold_q;
  logic [4:0]  jbits_q;
  logic [3:0]  depth_q;
  logic [5:0]  dpb_q;

  jump_result_t expected_jumps[$];
  int unsigned  errors = 0;
  bit           quiet  = 1'b0;  // set for the closing stretch: no idling
  int unsigned  stall_left = 0;

  directed_row_t rows   [NumRows];
  setting_t      phases [NumPhases];
  position_t     pool   [PoolSize];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic [63:0] splitmix(input logic [63:0] z);
    z = z + Golden;
    z = (z ^ (z >> 30)) * MultA;
    z = (z ^ (z >> 27)) * MultB;
    return z ^ (z >> 31);
  endfunction

  // Work out the result of one position and advance the walker's window.
  function automatic jump_result_t pick_jump(input position_t p);
    jump_result_t r;
    int unsigned  jb, dep, db, cnt, w;
    logic [63:0]  jmask, dmask, a, b, natural, h, anchor, esc;
    logic         hit;
    jb  = (jbits_q < 1) ? 1 : (jbits_q > 16) ? 16 : jbits_q;
    dep = (depth_q < 2) ? 2 : (depth_q > MaxHistory) ? MaxHistory : depth_q;
    db  = (dpb_q > 32) ? 32 : dpb_q;
    jmask = (64'd1 << jb) - 64'd1;
    dmask = (64'd1 << db) - 64'd1;
    w = 32'(p.walker);
    a = {p.w1[31:0], p.w0[63:32]};
    b = {p.w3[31:0], p.w2[63:32]};
    natural = (splitmix(a) ^ splitmix(b ^ SaltJump)) & jmask;
    h = splitmix(p.w0) ^ splitmix(p.w1) ^ splitmix(p.w2) ^ splitmix(p.w3);
    r.dp = ((p.w0 & dmask) == 64'd0);
    r.jump = natural[15:0];
    hit = 1'b0;
    if (p.reseed) begin
      orbit_fill[w] = 0;
    end else if (fold_q) begin
      cnt = (orbit_fill[w] > dep) ? dep : orbit_fill[w];
      for (int i = 0; i < cnt; i++) if (orbit_window[w][i] == h) hit = 1'b1;
      if (hit) begin
        // Escape from the smallest hash in the loop, never onto the natural jump.
        anchor = h;
        for (int i = 0; i < cnt; i++)
          if (orbit_window[w][i] < anchor) anchor = orbit_window[w][i];
        esc = splitmix(anchor ^ SaltEsc) & jmask;
        if (esc == natural) esc = (esc + 64'd1) & jmask;
        r.jump = esc[15:0];
        orbit_fill[w] = 0;
      end else if (cnt < dep) begin
        orbit_window[w][cnt] = h;
        orbit_fill[w] = cnt + 1;
      end else begin
        for (int i = 1; i < dep; i++) orbit_window[w][i-1] = orbit_window[w][i];
        orbit_window[w][dep-1] = h;
        orbit_fill[w] = dep;
      end
    end
    r.cycle = hit;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      RegFold:  fold_q  = val[0];
      RegJump:  jbits_q = val[4:0];
      RegDepth: depth_q = val[3:0];
      default:  dpb_q   = val[5:0];
    endcase
  endtask

  // Present one beat, hold it until taken, then predict. An optional typed
  // expectation overrides the predicted flags.
  task automatic send_position(input position_t p, input logic typed,
                               input logic cyc, input logic dp);
    jump_result_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    walker_i   <= p.walker;
    x_word0_i  <= p.w0;
    x_word1_i  <= p.w1;
    x_word2_i  <= p.w2;
    x_word3_i  <= p.w3;
    reseeded_i <= p.reseed;
    do @(posedge clk_i); while (in_stall_o);
    r = pick_jump(p);
    if (typed) begin
      r.cycle = cyc;
      r.dp    = dp;
    end
    expected_jumps.insert(expected_jumps.size(), r);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_jumps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  function automatic position_t rand_position;
    position_t p;
    p.walker = 8'($urandom_range(0, 255));
    p.w0 = rand64();
    // Clear a random run of low bits now and then so the DP test sees hits.
    if ($urandom_range(0, 1)) p.w0 = p.w0 & (Ones << $urandom_range(0, 40));
    p.w1 = rand64();
    p.w2 = rand64();
    p.w3 = rand64();
    p.reseed = 1'b0;
    return p;
  endfunction

  // Result side: random stall bursts, check each taken beat.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_jumps.size() == 0) begin
        report_mismatch("result beat with nothing expected", next_jump_o, 16'd0);
      end else begin
        jump_result_t e;
        e = expected_jumps.pop_front();
        if (next_jump_o !== e.jump) report_mismatch("next_jump", next_jump_o, e.jump);
        if (cycle_found_o !== e.cycle)
          report_mismatch("cycle_found", 16'(cycle_found_o), 16'(e.cycle));
        if (distinguished_o !== e.dp)
          report_mismatch("distinguished", 16'(distinguished_o), 16'(e.dp));
      end
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 7);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    position_t p;
    setting_t  s;
    fold_q  = 1'b1;
    jbits_q = 5'd5;
    depth_q = 4'd8;
    dpb_q   = 6'd0;
    foreach (orbit_fill[i]) orbit_fill[i] = 0;

    // Reset values: fold on, 5 jump bits, depth 8, no DP bits (every x is a DP).
    rows[0]  = '{'{8'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0}, 1'b1, 1'b0, 1'b1};
    rows[1]  = '{'{8'd0, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0}, 1'b1, 1'b1, 1'b1};
    rows[2]  = '{'{8'd255, Ones, Ones, Ones, Ones, 1'b0}, 1'b1, 1'b0, 1'b1};
    rows[3]  = '{'{8'd255, Ones, Ones, Ones, Ones, 1'b1}, 1'b1, 1'b0, 1'b1};
    rows[4]  = '{'{8'd255, Ones, Ones, Ones, Ones, 1'b0}, 1'b1, 1'b0, 1'b1};
    rows[5]  = '{'{8'd255, Ones, Ones, Ones, Ones, 1'b0}, 1'b1, 1'b1, 1'b1};
    rows[6]  = '{'{8'd7, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                   64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b0}, 1'b0, 1'b0, 1'b0};
    rows[7]  = '{'{8'd7, 64'h8000000000000000, 64'd1, 64'hFFFFFFFF00000000,
                   64'h00000000FFFFFFFF, 1'b0}, 1'b0, 1'b0, 1'b0};
    rows[8]  = '{'{8'd7, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
                   64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA, 1'b0}, 1'b0, 1'b0, 1'b0};
    rows[9]  = '{'{8'd128, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555,
                   64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1'b1}, 1'b0, 1'b0, 1'b0};
    rows[10] = '{'{8'd1, 64'hDEADBEEF00000000, 64'h0, 64'h1, 64'h2, 1'b0}, 1'b0, 1'b0, 1'b0};
    rows[11] = '{'{8'd1, 64'h0, 64'h0, 64'h0, 64'h0, 1'b0}, 1'b0, 1'b0, 1'b0};

    // Extremes and saturation: jump bits 0 and 31, depth 0 and 15, DP bits 63.
    phases[0] = '{6'd0, 6'd16, 6'd2,  6'd32};
    phases[1] = '{6'd1, 6'd1,  6'd2,  6'd63};
    phases[2] = '{6'd1, 6'd16, 6'd8,  6'd5};
    phases[3] = '{6'd1, 6'd0,  6'd0,  6'd1};
    phases[4] = '{6'd1, 6'd31, 6'd15, 6'd12};
    phases[5] = '{6'd1, 6'd8,  6'd3,  6'd0};
    phases[6] = '{6'd0, 6'd3,  6'd4,  6'd20};
    phases[7] = '{6'd1, 6'd12, 6'd5,  6'd8};
    phases[8] = '{6'd1, 6'd5,  6'd8,  6'd0};

    foreach (pool[i]) pool[i] = rand_position();

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_position(rows[i].pos, rows[i].typed, rows[i].cycle, rows[i].dp);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      s = phases[ph];
      quiet = (ph == NumPhases - 1);
      write_reg(RegFold,  s.fold);
      write_reg(RegJump,  s.jbits);
      write_reg(RegDepth, s.depth);
      write_reg(RegDp,    s.dpb);
      // Refresh part of the pool; the rest carries history across the change.
      pool[$urandom_range(0, PoolSize - 1)] = rand_position();
      pool[$urandom_range(0, PoolSize - 1)] = rand_position();
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 4) != 0) begin
          // Revisit pool positions on a few walkers so orbits close.
          p = pool[$urandom_range(0, PoolSize - 1)];
          p.walker = 8'($urandom_range(0, 3));
          p.reseed = ($urandom_range(0, 19) == 0);
        end else begin
          p = rand_position();
          p.reseed = 1'($urandom_range(0, 1));
        end
        send_position(p, 1'b0, 1'b0, 1'b0);
      end
      drain();
    end

    repeat (120) @(posedge clk_i);
    if (errors == 0 && expected_jumps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/wjce_pkg.sv
rtl/wjce_ram.sv
rtl/wjce_mix.sv
rtl/walker_jump_and_cycle_escape.sv
tb/sv/testbench.sv
